// ===== design/boi_pkg.sv =====
// ----------------------------------------------------------------------------
// boi_pkg: shared constants for the box overlap ratio block
// Default widths for box coordinates and for the fraction bits of the result.
// ----------------------------------------------------------------------------
package boi_pkg;

    // default width of every coordinate and size field
    localparam int COORD_BITS_DEF    = 12;

    // default number of bits after the point in the overlap ratio
    localparam int FRACTION_BITS_DEF = 16;

endpackage

// ===== design/boi_front.sv =====
// ----------------------------------------------------------------------------
// boi_front: overlap extents, box areas and union
// Three registered stages: extents, products, union. Moves when i_en is high.
// ----------------------------------------------------------------------------
module boi_front #(
    parameter int COORD_BITS = boi_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [COORD_BITS-1:0]     i_a_left,
    input  logic [COORD_BITS-1:0]     i_a_top,
    input  logic [COORD_BITS-1:0]     i_a_width,
    input  logic [COORD_BITS-1:0]     i_a_height,
    input  logic [COORD_BITS-1:0]     i_b_left,
    input  logic [COORD_BITS-1:0]     i_b_top,
    input  logic [COORD_BITS-1:0]     i_b_width,
    input  logic [COORD_BITS-1:0]     i_b_height,
    output logic                      o_valid,
    output logic                      o_zero,
    output logic [2*COORD_BITS+1:0]   o_rem,
    output logic [2*COORD_BITS:0]     o_den
);

    localparam int C     = COORD_BITS;
    localparam int AREA_W = 2 * C;
    localparam int UNI_W  = 2 * C + 1;
    localparam int REM_W  = 2 * C + 2;

    // edge positions at full width, right and bottom never wrap
    logic [C:0]   a_right, b_right, a_bottom, b_bottom;
    logic [C:0]   x_lo, x_hi, y_lo, y_hi;
    logic [C:0]   x_diff, y_diff;
    logic [C-1:0] n_ex, n_ey;

    assign a_right  = {1'b0, i_a_left} + {1'b0, i_a_width};
    assign b_right  = {1'b0, i_b_left} + {1'b0, i_b_width};
    assign a_bottom = {1'b0, i_a_top}  + {1'b0, i_a_height};
    assign b_bottom = {1'b0, i_b_top}  + {1'b0, i_b_height};

    assign x_lo = (i_a_left > i_b_left) ? {1'b0, i_a_left} : {1'b0, i_b_left};
    assign y_lo = (i_a_top  > i_b_top)  ? {1'b0, i_a_top}  : {1'b0, i_b_top};
    assign x_hi = (a_right  < b_right)  ? a_right  : b_right;
    assign y_hi = (a_bottom < b_bottom) ? a_bottom : b_bottom;

    // overlap never exceeds either length, so it fits a coordinate field
    assign x_diff = x_hi - x_lo;
    assign y_diff = y_hi - y_lo;
    assign n_ex   = (x_hi > x_lo) ? x_diff[C-1:0] : '0;
    assign n_ey   = (y_hi > y_lo) ? y_diff[C-1:0] : '0;

    // stage 1: extents and box sizes
    logic         r_v1;
    logic [C-1:0] r_ex, r_ey, r_aw, r_ah, r_bw, r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex <= n_ex;
            r_ey <= n_ey;
            r_aw <= i_a_width;
            r_ah <= i_a_height;
            r_bw <= i_b_width;
            r_bh <= i_b_height;
        end
    end

    // stage 2: the three products
    logic              r_v2;
    logic [AREA_W-1:0] r_area_a, r_area_b, r_inter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_area_a <= r_aw * r_ah;
            r_area_b <= r_bw * r_bh;
            r_inter  <= r_ex * r_ey;
        end
    end

    // stage 3: union and zero-union flag
    logic [UNI_W-1:0]  n_uni;
    logic              r_v3;
    logic              r_zero;
    logic [UNI_W-1:0]  r_uni;
    logic [AREA_W-1:0] r_inter3;

    assign n_uni = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_uni    <= n_uni;
            r_zero   <= (n_uni == '0);
            r_inter3 <= r_inter;
        end
    end

    assign o_valid = r_v3;
    assign o_zero  = r_zero;
    assign o_rem   = {{(REM_W - AREA_W){1'b0}}, r_inter3};
    assign o_den   = r_uni;

endmodule

// ===== design/boi_div_cell.sv =====
// ----------------------------------------------------------------------------
// boi_div_cell: one quotient bit of the overlap over union division
// Compares the running remainder with the union, subtracts when it fits,
// shifts the remainder left and hands everything to the next cell.
// ----------------------------------------------------------------------------
module boi_div_cell #(
    parameter int COORD_BITS    = boi_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = boi_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_zero,
    input  logic [2*COORD_BITS+1:0]  i_rem,
    input  logic [2*COORD_BITS:0]    i_den,
    input  logic [FRACTION_BITS:0]   i_quot,
    output logic                     o_valid,
    output logic                     o_zero,
    output logic [2*COORD_BITS+1:0]  o_rem,
    output logic [2*COORD_BITS:0]    o_den,
    output logic [FRACTION_BITS:0]   o_quot
);

    localparam int REM_W = 2 * COORD_BITS + 2;
    localparam int Q_W   = FRACTION_BITS + 1;

    logic             fits;
    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] rem_sub;
    logic [REM_W-1:0] n_rem;
    logic [Q_W-1:0]   n_quot;

    // compare and subtract; the kept remainder is below the union
    assign den_ext = {1'b0, i_den};
    assign fits    = (i_rem >= den_ext);
    assign rem_sub = fits ? (i_rem - den_ext) : i_rem;
    assign n_rem   = {rem_sub[REM_W-2:0], 1'b0};
    assign n_quot  = {i_quot[Q_W-2:0], fits};

    // valid bit
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    logic             r_zero;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-2:0] r_den;
    logic [Q_W-1:0]   r_quot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= i_zero;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quot  = r_quot;

endmodule

// ===== design/box_intersection_over_union.sv =====
// Throughput: one transaction per cycle unless the output stalls; three front
// stages feed a chain of FRACTION_BITS + 1 division cells, each resolving one quotient bit.
// The whole pipeline advances together whenever the output register is free.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// box_intersection_over_union: overlap over union of two boxes
// Computes floor(overlap * 2^FRACTION_BITS / union), zero when union is zero.
// ----------------------------------------------------------------------------
module box_intersection_over_union #(
    parameter int COORD_BITS    = boi_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = boi_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [COORD_BITS-1:0]    i_a_left,
    input  logic [COORD_BITS-1:0]    i_a_top,
    input  logic [COORD_BITS-1:0]    i_a_width,
    input  logic [COORD_BITS-1:0]    i_a_height,
    input  logic [COORD_BITS-1:0]    i_b_left,
    input  logic [COORD_BITS-1:0]    i_b_top,
    input  logic [COORD_BITS-1:0]    i_b_width,
    input  logic [COORD_BITS-1:0]    i_b_height,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [FRACTION_BITS:0]   o_overlap_ratio
);

    localparam int REM_W = 2 * COORD_BITS + 2;
    localparam int DEN_W = 2 * COORD_BITS + 1;
    localparam int Q_W   = FRACTION_BITS + 1;

    // pipeline advances when the output register is empty or being taken
    logic en;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // links between the front end and the cells
    logic             w_valid [0:Q_W];
    logic             w_zero  [0:Q_W];
    logic [REM_W-1:0] w_rem   [0:Q_W];
    logic [DEN_W-1:0] w_den   [0:Q_W];
    logic [Q_W-1:0]   w_quot  [0:Q_W];

    // extents, areas and union
    boi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_width  (i_a_width),
        .i_a_height (i_a_height),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_width  (i_b_width),
        .i_b_height (i_b_height),
        .o_valid    (w_valid[0]),
        .o_zero     (w_zero[0]),
        .o_rem      (w_rem[0]),
        .o_den      (w_den[0])
    );

    assign w_quot[0] = '0;

    // chain of division cells, most significant quotient bit first
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        boi_div_cell #(
            .COORD_BITS    (COORD_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[k]),
            .i_zero  (w_zero[k]),
            .i_rem   (w_rem[k]),
            .i_den   (w_den[k]),
            .i_quot  (w_quot[k]),
            .o_valid (w_valid[k+1]),
            .o_zero  (w_zero[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_den   (w_den[k+1]),
            .o_quot  (w_quot[k+1])
        );
    end

    // zero union forces a zero ratio
    assign o_valid         = w_valid[Q_W];
    assign o_overlap_ratio = w_zero[Q_W] ? '0 : w_quot[Q_W];

`ifndef SYNTHESIS
    localparam logic [Q_W-1:0] ONE = {1'b1, {(Q_W-1){1'b0}}};

    // ratio never exceeds one
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_overlap_ratio <= ONE))
        else $error("overlap ratio above one");

    // a ratio of one carries no fraction bits
    a_one_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overlap_ratio[Q_W-1]) |-> (o_overlap_ratio == ONE))
        else $error("overlap ratio integer bit set with fraction bits");

    // input side is only held back by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // a blocked result holds the whole chain, so the result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(w_quot[Q_W])))
        else $error("result changed while blocked");
`endif

endmodule
